### hw/rtl/rbbs_pkg.sv
// Shared constants, field widths and types for the rate-based bitrate selector.
// No dependencies; used by every module of the block through scoped names.
`default_nettype none

package rbbs_pkg;

    localparam int HIST_DEPTH = 8;
    localparam int MAX_REPS   = 6;

    localparam int HIST_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HIST_CW = $clog2(HIST_DEPTH + 1);
    localparam int REP_AW  = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1;

    localparam int CMD_W   = 1;
    localparam int BYTES_W = 32;
    localparam int MS_W    = 32;
    localparam int FILL_W  = 17;
    localparam int IDX_W   = 3;
    localparam int BW_W    = 32;
    localparam int EST_W   = 32;
    localparam int STAT_W  = 2;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 72;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam int RATE_W = 48;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 45;
    localparam int SUM_W  = RATE_W + HIST_CW;
    localparam int PH_W   = RATE_W - FRAC_W + FILL_W;
    localparam int PL_W   = FRAC_W + FILL_W;
    localparam int TOT_W  = PH_W + 1;

    localparam int DIV_NW = SUM_W;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam logic [CMD_W-1:0] CMD_RECORD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SELECT = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_TIME = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_HIST   = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_REP_COUNT = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_REP_BW0   = 3'd1;

    localparam logic [IDX_W-1:0] REP_COUNT_RST = 3'd1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [BW_W-1:0]  bw;
    } t_pick;

endpackage

`default_nettype wire

### hw/rtl/rbbs_hist_mem.sv
// Rate history memory: synchronous RAM with registered read.
// Per-entry valid bits make never-written entries read as zero. Uses rbbs_pkg.
`default_nettype none

module rbbs_hist_mem (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_we,
    input  wire  [rbbs_pkg::HIST_AW-1:0]     i_waddr,
    input  wire  [rbbs_pkg::RATE_W-1:0]      i_wdata,
    input  wire  [rbbs_pkg::HIST_AW-1:0]     i_raddr,
    output logic [rbbs_pkg::RATE_W-1:0]      o_rdata
);

    logic [rbbs_pkg::RATE_W-1:0]     r_mem [rbbs_pkg::HIST_DEPTH];
    logic [rbbs_pkg::HIST_DEPTH-1:0] r_valid;
    logic [rbbs_pkg::RATE_W-1:0]     r_rd_data;
    logic                            r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

### hw/rtl/rbbs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the rate computation and the history average. Uses rbbs_pkg.
`default_nettype none

module rbbs_div (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire  [rbbs_pkg::DIV_NW-1:0]   i_dividend,
    input  wire  [rbbs_pkg::DIV_DW-1:0]   i_divisor,
    output logic                          o_done,
    output logic [rbbs_pkg::DIV_NW-1:0]   o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [rbbs_pkg::DIV_CW-1:0]   r_cnt;
    logic [rbbs_pkg::DIV_NW-1:0]   r_quo;
    logic [rbbs_pkg::DIV_DW-1:0]   r_rem;
    logic [rbbs_pkg::DIV_DW-1:0]   r_div;

    logic [rbbs_pkg::DIV_DW:0]     w_shift;
    logic [rbbs_pkg::DIV_DW:0]     w_diff;
    logic                          w_ge;

    assign w_shift = {r_rem, r_quo[rbbs_pkg::DIV_NW-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rbbs_pkg::DIV_CW'(rbbs_pkg::DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rbbs_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[rbbs_pkg::DIV_DW-1:0] : w_shift[rbbs_pkg::DIV_DW-1:0];
            r_quo <= {r_quo[rbbs_pkg::DIV_NW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### hw/rtl/rbbs_rep_sel.sv
// Representation table and sequential selection: one entry compared per cycle,
// a minimum pass then a best-fit pass. Holds the configuration registers. Uses rbbs_pkg.
`default_nettype none

module rbbs_rep_sel (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [rbbs_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire  [rbbs_pkg::CFG_DW-1:0]   i_cfg_data,
    input  wire                           i_start,
    input  wire  [rbbs_pkg::EST_W-1:0]    i_est,
    output logic                          o_done,
    output rbbs_pkg::t_pick               o_pick
);

    logic [rbbs_pkg::IDX_W-1:0] r_rep_count;
    logic [rbbs_pkg::BW_W-1:0]  r_rep_bw [rbbs_pkg::MAX_REPS];

    logic                       r_busy;
    logic                       r_pass;
    logic                       r_done;
    logic [rbbs_pkg::IDX_W-1:0] r_idx;
    logic [rbbs_pkg::IDX_W-1:0] r_best_idx;
    logic [rbbs_pkg::BW_W-1:0]  r_best_bw;

    logic [rbbs_pkg::IDX_W-1:0] w_n;
    logic [rbbs_pkg::BW_W-1:0]  w_bw;
    logic                       w_take;
    logic                       w_bw_addr;
    logic [rbbs_pkg::REP_AW-1:0] w_bw_sel;

    always_comb begin
        w_n = r_rep_count;
        if (r_rep_count == '0) begin
            w_n = rbbs_pkg::IDX_W'(1);
        end else if (r_rep_count > rbbs_pkg::IDX_W'(rbbs_pkg::MAX_REPS)) begin
            w_n = rbbs_pkg::IDX_W'(rbbs_pkg::MAX_REPS);
        end
    end

    assign w_bw   = r_rep_bw[r_idx[rbbs_pkg::REP_AW-1:0]];
    assign w_take = r_pass ? ({1'b0, w_bw} <= {1'b0, i_est} && w_bw > r_best_bw)
                           : (w_bw < r_best_bw);

    assign w_bw_addr = i_cfg_addr >= rbbs_pkg::CFG_REP_BW0 &&
                       i_cfg_addr <= rbbs_pkg::CFG_AW'(rbbs_pkg::MAX_REPS);
    assign w_bw_sel  = rbbs_pkg::REP_AW'(i_cfg_addr - rbbs_pkg::CFG_REP_BW0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_count <= rbbs_pkg::REP_COUNT_RST;
            for (int i = 0; i < rbbs_pkg::MAX_REPS; i++) begin
                r_rep_bw[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == rbbs_pkg::CFG_REP_COUNT) begin
                r_rep_count <= i_cfg_data[rbbs_pkg::IDX_W-1:0];
            end else if (w_bw_addr) begin
                r_rep_bw[w_bw_sel] <= i_cfg_data[rbbs_pkg::BW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pass <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pass <= 1'b0;
                r_idx  <= rbbs_pkg::IDX_W'(1);
            end else if (r_busy) begin
                if (r_idx < w_n) begin
                    r_idx <= r_idx + 1'b1;
                end else if (!r_pass) begin
                    r_pass <= 1'b1;
                    r_idx  <= '0;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_best_idx <= '0;
            r_best_bw  <= r_rep_bw[0];
        end else if (r_busy && r_idx < w_n && w_take) begin
            r_best_idx <= r_idx;
            r_best_bw  <= w_bw;
        end
    end

    assign o_done     = r_done;
    assign o_pick.idx = r_best_idx;
    assign o_pick.bw  = r_best_bw;

endmodule

`default_nettype wire

### hw/rtl/rate_based_bitrate_selector.sv
// Rate-based bitrate selector: one word in flight. A record word runs through the shared
// divider, then loads the output register. A zero-duration record skips the divider and
// goes straight to the output load. A select word walks the history, runs the divider,
// scales the average (high product, low product, add), walks the representation table
// and loads the output; with no history it skips the divider and scaling. The next word
// is taken the cycle after the result loads. Reset is synchronous.
`default_nettype none

module rate_based_bitrate_selector (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [rbbs_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  wire  [rbbs_pkg::CFG_DW-1:0]         i_cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // segment_bytes, elapsed_ms, fill_fraction, zero pad
    input  wire  [rbbs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // command
    input  wire  [rbbs_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // chosen_index, chosen_bandwidth, rate_estimate, zero pad
    output logic [rbbs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // status
    output logic [rbbs_pkg::STAT_W-1:0]         m_axis_tuser
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_REC_DIV = 4'd1;
    localparam logic [3:0] S_SUM     = 4'd2;
    localparam logic [3:0] S_AVG_DIV = 4'd3;
    localparam logic [3:0] S_MUL_HI  = 4'd4;
    localparam logic [3:0] S_MUL_LO  = 4'd5;
    localparam logic [3:0] S_ADD     = 4'd6;
    localparam logic [3:0] S_PICK    = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    localparam int MS_LO   = rbbs_pkg::BYTES_W;
    localparam int FILL_LO = rbbs_pkg::BYTES_W + rbbs_pkg::MS_W;
    localparam int PAD_W   = rbbs_pkg::M_TDATA_W - rbbs_pkg::IDX_W - rbbs_pkg::BW_W
                             - rbbs_pkg::EST_W;

    logic [3:0]                       r_state;
    logic [3:0]                       n_state;
    logic [rbbs_pkg::HIST_AW-1:0]     r_wptr;
    logic [rbbs_pkg::HIST_CW-1:0]     r_walk;
    logic [rbbs_pkg::HIST_CW-1:0]     r_cnt;
    logic [rbbs_pkg::SUM_W-1:0]       r_sum;
    logic [rbbs_pkg::FILL_W-1:0]      r_fill;
    logic [rbbs_pkg::RATE_W-1:0]      r_avg;
    logic [rbbs_pkg::PH_W-1:0]        r_prod_hi;
    logic [rbbs_pkg::PL_W-1:0]        r_prod_lo;
    logic [rbbs_pkg::EST_W-1:0]       r_est;
    logic [rbbs_pkg::STAT_W-1:0]      r_status;
    rbbs_pkg::t_pick                  r_res;
    logic                             r_m_valid;
    logic [rbbs_pkg::M_TDATA_W-1:0]   r_m_tdata;
    logic [rbbs_pkg::STAT_W-1:0]      r_m_tuser;

    logic                             w_in_acc;
    logic [rbbs_pkg::BYTES_W-1:0]     w_bytes;
    logic [rbbs_pkg::MS_W-1:0]        w_ms;
    logic [rbbs_pkg::FILL_W-1:0]      w_fill;
    logic [rbbs_pkg::PROD_W-1:0]      w_prod;

    logic                             w_div_start;
    logic [rbbs_pkg::DIV_NW-1:0]      w_div_num;
    logic [rbbs_pkg::DIV_DW-1:0]      w_div_den;
    logic                             w_div_done;
    logic [rbbs_pkg::DIV_NW-1:0]      w_quo;

    logic [rbbs_pkg::RATE_W-1:0]      w_rd;
    logic                             w_we;
    logic [rbbs_pkg::RATE_W-1:0]      w_rate;
    logic [rbbs_pkg::EST_W-1:0]       w_rate_clip;

    logic                             w_walk_end;
    logic [rbbs_pkg::SUM_W-1:0]       w_sum_nx;
    logic [rbbs_pkg::HIST_CW-1:0]     w_cnt_nx;

    logic [rbbs_pkg::TOT_W-1:0]       w_tot;
    logic                             w_pick_start;
    logic                             w_pick_done;
    rbbs_pkg::t_pick                  w_pick;
    logic                             w_out_load;

    assign w_bytes = s_axis_tdata[rbbs_pkg::BYTES_W-1:0];
    assign w_ms    = s_axis_tdata[FILL_LO-1:MS_LO];
    assign w_fill  = s_axis_tdata[FILL_LO+rbbs_pkg::FILL_W-1:FILL_LO];

    assign s_axis_tready = i_rst_n && r_state == S_IDLE;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // x8000 = x8192 - x128 - x64
    assign w_prod = (rbbs_pkg::PROD_W'(w_bytes) << 13) - (rbbs_pkg::PROD_W'(w_bytes) << 7)
                  - (rbbs_pkg::PROD_W'(w_bytes) << 6);

    assign w_walk_end = r_walk == rbbs_pkg::HIST_CW'(rbbs_pkg::HIST_DEPTH);

    always_comb begin
        w_sum_nx = r_sum;
        w_cnt_nx = r_cnt;
        if (r_walk != '0 && w_rd != '0) begin
            w_sum_nx = r_sum + rbbs_pkg::SUM_W'(w_rd);
            w_cnt_nx = r_cnt + 1'b1;
        end
    end

    assign w_div_start = (w_in_acc && s_axis_tuser == rbbs_pkg::CMD_RECORD && w_ms != '0)
                      || (r_state == S_SUM && w_walk_end && w_cnt_nx != '0);
    assign w_div_num   = (r_state == S_IDLE) ? rbbs_pkg::DIV_NW'(w_prod) : w_sum_nx;
    assign w_div_den   = (r_state == S_IDLE) ? w_ms : rbbs_pkg::DIV_DW'(w_cnt_nx);

    assign w_rate      = (|w_quo[rbbs_pkg::DIV_NW-1:rbbs_pkg::RATE_W]) ? '1
                                                               : w_quo[rbbs_pkg::RATE_W-1:0];
    assign w_rate_clip = (|w_rate[rbbs_pkg::RATE_W-1:rbbs_pkg::EST_W]) ? '1
                                                               : w_rate[rbbs_pkg::EST_W-1:0];
    assign w_we        = r_state == S_REC_DIV && w_div_done;

    assign w_tot = rbbs_pkg::TOT_W'(r_prod_hi)
                 + rbbs_pkg::TOT_W'(r_prod_lo[rbbs_pkg::PL_W-1:rbbs_pkg::FRAC_W]);

    assign w_pick_start = r_state == S_ADD || (r_state == S_SUM && w_walk_end && w_cnt_nx == '0);
    assign w_out_load   = r_state == S_DONE && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == rbbs_pkg::CMD_SELECT) begin
                        n_state = S_SUM;
                    end else if (w_ms == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_REC_DIV;
                    end
                end
            end
            S_REC_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_SUM: begin
                if (w_walk_end) begin
                    n_state = (w_cnt_nx == '0) ? S_PICK : S_AVG_DIV;
                end
            end
            S_AVG_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL_HI;
                end
            end
            S_MUL_HI: n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_ADD;
            S_ADD:    n_state = S_PICK;
            S_PICK: begin
                if (w_pick_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wptr    <= '0;
            r_walk    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_wptr <= (r_wptr == rbbs_pkg::HIST_AW'(rbbs_pkg::HIST_DEPTH - 1)) ? '0
                                                                            : r_wptr + 1'b1;
            end
            if (w_in_acc) begin
                r_walk <= '0;
            end else if (r_state == S_SUM) begin
                r_walk <= r_walk + 1'b1;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_fill <= w_fill;
            r_sum  <= '0;
            r_cnt  <= '0;
            r_res  <= '0;
            r_est  <= '0;
            r_status <= (s_axis_tuser == rbbs_pkg::CMD_RECORD && w_ms == '0)
                      ? rbbs_pkg::ST_ZERO_TIME : rbbs_pkg::ST_OK;
        end
        if (r_state == S_SUM) begin
            r_sum <= w_sum_nx;
            r_cnt <= w_cnt_nx;
            if (w_walk_end && w_cnt_nx == '0) begin
                r_status <= rbbs_pkg::ST_NO_HIST;
            end
        end
        if (w_we) begin
            r_est <= w_rate_clip;
        end
        if (r_state == S_AVG_DIV && w_div_done) begin
            r_avg <= w_quo[rbbs_pkg::RATE_W-1:0];
        end
        if (r_state == S_MUL_HI) begin
            r_prod_hi <= rbbs_pkg::PH_W'(r_avg[rbbs_pkg::RATE_W-1:rbbs_pkg::FRAC_W])
                       * rbbs_pkg::PH_W'(r_fill);
        end
        if (r_state == S_MUL_LO) begin
            r_prod_lo <= rbbs_pkg::PL_W'(r_avg[rbbs_pkg::FRAC_W-1:0])
                       * rbbs_pkg::PL_W'(r_fill);
        end
        if (r_state == S_ADD) begin
            r_est <= (|w_tot[rbbs_pkg::TOT_W-1:rbbs_pkg::EST_W]) ? '1
                                                                : w_tot[rbbs_pkg::EST_W-1:0];
        end
        if (r_state == S_PICK && w_pick_done) begin
            r_res <= w_pick;
        end
        if (w_out_load) begin
            r_m_tdata <= {{PAD_W{1'b0}}, r_est, r_res.bw, r_res.idx};
            r_m_tuser <= r_status;
        end
    end

    rbbs_hist_mem u_hist_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (r_wptr),
        .i_wdata (w_rate),
        .i_raddr (r_walk[rbbs_pkg::HIST_AW-1:0]),
        .o_rdata (w_rd)
    );

    rbbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    rbbs_rep_sel u_rep_sel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_start    (w_pick_start),
        .i_est      (r_est),
        .o_done     (w_pick_done),
        .o_pick     (w_pick)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_REC_DIV || r_state == S_AVG_DIV))
        else $error("divider finished with no word waiting on it");

    a_pick_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pick_done |-> r_state == S_PICK)
        else $error("selection finished outside the pick phase");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (m_axis_tvalid && s_axis_tready))
        else $error("result load did not raise output valid and free the input");

    a_wptr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_we |=> $stable(r_wptr))
        else $error("write pointer moved without a history write");

endmodule

`default_nettype wire

### tb/tb_rate_based_bitrate_selector.sv
// Self-checking testbench for rate_based_bitrate_selector: stream words in and out, a
// per-word prediction of the rate history and representation choice, compared field by field.
// Depends on rbbs_pkg and the rate_based_bitrate_selector RTL.

module tb_rate_based_bitrate_selector;

    import rbbs_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_SPARE = CFG_AW'(int'(CFG_REP_BW0) + MAX_REPS);
    localparam logic [63:0] RATE_CAP = (64'd1 << RATE_W) - 64'd1;
    localparam logic [63:0] EST_CAP  = 64'hFFFF_FFFF;
    localparam int S_PAD_W = S_TDATA_W - BYTES_W - MS_W - FILL_W;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BYTES_W-1:0] seg_bytes;
        logic [MS_W-1:0]    ms;
        logic [FILL_W-1:0]  fill;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [BW_W-1:0]   bw;
        logic [EST_W-1:0]  est;
        logic [STAT_W-1:0] status;
    } choice_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr = '0;
    logic [CFG_DW-1:0]     i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // segment_bytes, elapsed_ms, fill_fraction, zero pad
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    // command
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // chosen_index, chosen_bandwidth, rate_estimate, zero pad
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // status
    logic [STAT_W-1:0]     m_axis_tuser;

    rate_based_bitrate_selector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [RATE_W-1:0] rate_ring [HIST_DEPTH];
    int                ring_ptr;
    logic [2:0]        rep_limit;
    logic [BW_W-1:0]   rep_rate [MAX_REPS];
    logic [BW_W-1:0]   next_bw [MAX_REPS];

    request_t pending_q [$];
    choice_t  choice_q [$];
    int       mismatch_count = 0;
    int       result_count = 0;

    task automatic apply_request(input request_t rq);
        choice_t     c;
        logic [63:0] rate;
        logic [63:0] sum;
        logic [63:0] cnt;
        logic [63:0] avg;
        logic [63:0] est;
        int          n;
        int          best;
        int          i;
        c = '0;
        if (rq.cmd == CMD_RECORD) begin
            if (rq.ms == '0) begin
                c.status = ST_ZERO_TIME;
            end else begin
                rate = (64'(rq.seg_bytes) * 64'd8000) / 64'(rq.ms);
                if (rate > RATE_CAP) rate = RATE_CAP;
                rate_ring[ring_ptr] = rate[RATE_W-1:0];
                ring_ptr = (ring_ptr == HIST_DEPTH - 1) ? 0 : ring_ptr + 1;
                c.est = (rate > EST_CAP) ? EST_CAP[EST_W-1:0] : rate[EST_W-1:0];
                c.status = ST_OK;
            end
        end else begin
            sum = '0;
            cnt = '0;
            est = '0;
            for (i = 0; i < HIST_DEPTH; i++) begin
                if (rate_ring[i] != '0) begin
                    sum = sum + 64'(rate_ring[i]);
                    cnt = cnt + 64'd1;
                end
            end
            if (cnt != '0) begin
                avg = sum / cnt;
                est = (avg >> 16) * 64'(rq.fill) + (((avg & 64'hFFFF) * 64'(rq.fill)) >> 16);
                if (est > EST_CAP) est = EST_CAP;
            end
            n = int'(rep_limit);
            if (n == 0) n = 1;
            if (n > MAX_REPS) n = MAX_REPS;
            best = 0;
            for (i = 1; i < n; i++)
                if (rep_rate[i] < rep_rate[best]) best = i;
            for (i = 0; i < n; i++)
                if (64'(rep_rate[i]) <= est && rep_rate[i] > rep_rate[best]) best = i;
            c.idx = IDX_W'(best);
            c.bw = rep_rate[best];
            c.est = est[EST_W-1:0];
            c.status = (cnt != '0) ? ST_OK : ST_NO_HIST;
        end
        choice_q.push_back(c);
    endtask

    task automatic report_miss(input string what, input choice_t want, input choice_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("word %0d %s: expected idx=%0d bw=%0d est=%0d st=%0d",
                   result_count, what, want.idx, want.bw, want.est, want.status);
            $display(" got idx=%0d bw=%0d est=%0d st=%0d",
                     got.idx, got.bw, got.est, got.status);
        end
    endtask

    // sender: bursts of words with random gaps
    request_t cur_req;
    logic     offering;
    int       burst_left;
    int       gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(cur_req);
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (pending_q.size() != 0) begin
                    cur_req = pending_q.pop_front();
                    offering = 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6:    gap_left = $urandom_range(1, 10);
                            default:    gap_left = $urandom_range(10, 120);
                        endcase
                    end
                end
            end
            s_axis_tvalid <= offering;
            s_axis_tdata  <= {{S_PAD_W{1'b0}}, cur_req.fill, cur_req.ms, cur_req.seg_bytes};
            s_axis_tuser  <= cur_req.cmd;
        end
    end

    // receiver: stall pattern, plus one long hold to back up the input
    int  rx_taken;
    int  hold_left;
    bit  hold_done;
    int  rx_mode;
    int  mode_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_taken = 0;
            hold_left = 0;
            hold_done = 1'b0;
            rx_mode = 0;
            mode_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) rx_taken = rx_taken + 1;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && rx_taken >= 150) begin
                hold_done = 1'b1;
                hold_left = 600;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(32, 256);
                end else begin
                    mode_left = mode_left - 1;
                end
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    default: m_axis_tready <= ($urandom_range(0, 6) == 0);
                endcase
            end
        end
    end

    choice_t got_choice;
    choice_t want_choice;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_choice.idx    = m_axis_tdata[IDX_W-1:0];
            got_choice.bw     = m_axis_tdata[IDX_W +: BW_W];
            got_choice.est    = m_axis_tdata[IDX_W+BW_W +: EST_W];
            got_choice.status = m_axis_tuser;
            if (choice_q.size() == 0) begin
                report_miss("unexpected", '0, got_choice);
            end else begin
                want_choice = choice_q.pop_front();
                if (got_choice.idx !== want_choice.idx || got_choice.bw !== want_choice.bw ||
                    got_choice.est !== want_choice.est ||
                    got_choice.status !== want_choice.status)
                    report_miss("mismatch", want_choice, got_choice);
            end
            result_count++;
        end
    end

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        int k;
        k = int'(idx) - int'(CFG_REP_BW0);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        if (idx == CFG_REP_COUNT)
            rep_limit = val[2:0];
        else if (k >= 0 && k < MAX_REPS)
            rep_rate[k] = val;
    endtask

    task automatic load_table(input logic [2:0] count);
        int i;
        write_reg(CFG_REP_COUNT, CFG_DW'(count));
        for (i = 0; i < MAX_REPS; i++)
            write_reg(CFG_AW'(int'(CFG_REP_BW0) + i), next_bw[i]);
        write_reg(CFG_SPARE, $urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [BYTES_W-1:0] b,
                            input logic [MS_W-1:0] m, input logic [FILL_W-1:0] f);
        request_t rq;
        rq.cmd = cmd;
        rq.seg_bytes = b;
        rq.ms = m;
        rq.fill = f;
        pending_q.push_back(rq);
    endtask

    task automatic wait_drained;
        while (pending_q.size() != 0 || offering || s_axis_tvalid || choice_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        #6_000_000;
        $display("tb_rate_based_bitrate_selector: errors");
        $finish;
    end

    request_t   rq;
    logic [2:0] phase_count;

    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) rate_ring[i] = '0;
        ring_ptr = 0;
        rep_limit = REP_COUNT_RST;
        for (int i = 0; i < MAX_REPS; i++) rep_rate[i] = '0;
        offering = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        next_bw[0] = 32'd4_000_000;
        next_bw[1] = 32'd1_000_000;
        next_bw[2] = 32'd2_500_000;
        next_bw[3] = 32'd1_000_000;
        next_bw[4] = 32'hFFFF_FFFF;
        next_bw[5] = 32'd250_000;
        load_table(3'd6);

        // empty history, zero duration, zero rate, exact and saturated scaling
        push_req(CMD_SELECT, 32'd0, 32'd0, 17'h10000);
        push_req(CMD_RECORD, 32'd1234, 32'd0, 17'h1FFFF);
        push_req(CMD_RECORD, 32'd0, 32'd5, 17'h0);
        push_req(CMD_SELECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
        push_req(CMD_RECORD, 32'd125_000, 32'd1000, 17'h0);
        push_req(CMD_SELECT, 32'd0, 32'd0, 17'h10000);
        push_req(CMD_SELECT, 32'd0, 32'd0, 17'h08000);
        push_req(CMD_RECORD, 32'hFFFF_FFFF, 32'd1, 17'h0);
        push_req(CMD_SELECT, 32'd0, 32'd0, 17'h0);
        push_req(CMD_SELECT, 32'd0, 32'd0, 17'h1FFFF);
        push_req(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h0);
        push_req(CMD_RECORD, 32'd1, 32'hFFFF_FFFF, 17'h0);
        push_req(CMD_SELECT, 32'd0, 32'd0, 17'h10000);
        repeat (6)
            push_req(CMD_RECORD, $urandom_range(20_000, 4_000_000), $urandom_range(40, 4000),
                     FILL_W'($urandom));
        push_req(CMD_SELECT, 32'd0, 32'd0, 17'h10000);
        push_req(CMD_SELECT, 32'd0, 32'd0, 17'h00001);

        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            for (int i = 0; i < MAX_REPS; i++) begin
                case ($urandom_range(0, 9))
                    0:       next_bw[i] = '0;
                    1:       next_bw[i] = 32'hFFFF_FFFF;
                    2:       next_bw[i] = (i == 0) ? 32'd1_000_000 : next_bw[i-1];
                    3:       next_bw[i] = $urandom;
                    default: next_bw[i] = $urandom_range(100_000, 300_000_000);
                endcase
                if (phase == 3) next_bw[i] = 32'hFFFF_FFFF;
                if (phase == 4) next_bw[i] = '0;
            end
            case (phase)
                0:       phase_count = 3'd0;
                1:       phase_count = 3'd7;
                2:       phase_count = 3'd1;
                3, 4:    phase_count = 3'd6;
                default: phase_count = 3'($urandom_range(0, 7));
            endcase
            load_table(phase_count);

            repeat (60) begin
                rq.seg_bytes = $urandom;
                rq.ms = $urandom;
                rq.fill = FILL_W'($urandom);
                if ($urandom_range(0, 1) == 0) begin
                    rq.cmd = CMD_RECORD;
                    case ($urandom_range(0, 19))
                        0:       rq.ms = '0;
                        1:       rq.seg_bytes = '0;
                        2:       rq.ms = $urandom_range(1, 4);
                        3, 4:    ;
                        default: begin
                            rq.seg_bytes = $urandom_range(20_000, 4_000_000);
                            rq.ms = $urandom_range(40, 4000);
                        end
                    endcase
                end else begin
                    rq.cmd = CMD_SELECT;
                    case ($urandom_range(0, 9))
                        0:       rq.fill = 17'h10000;
                        1:       ;
                        default: rq.fill = FILL_W'($urandom_range(0, 65536));
                    endcase
                end
                pending_q.push_back(rq);
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && choice_q.size() == 0)
            $display("tb_rate_based_bitrate_selector: clean");
        else
            $display("tb_rate_based_bitrate_selector: errors");
        $finish;
    end

endmodule
